// ===== design/ccns_pkg.sv =====
// Shared types and constants of the cover-crop nearest scaler address generator.
package ccns_pkg;

	localparam int FIELD_W = 11;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_SRC_W = 2'd0,
		REG_SRC_H = 2'd1,
		REG_TGT_W = 2'd2,
		REG_TGT_H = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [FIELD_W-1:0] out_x;
		logic [FIELD_W-1:0] out_y;
	} coord_t;

	typedef struct packed {
		logic [FIELD_W-1:0] src_x;
		logic [FIELD_W-1:0] src_y;
		logic               clamped;
	} addr_t;

endpackage

// ===== design/ccns_cfg.sv =====
// Register file and the per-image constants derived from the four size registers.
module ccns_cfg #(
	parameter int CB = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ccns_pkg::PADDR_W-1:0]  paddr,
	input  logic [ccns_pkg::PDATA_W-1:0]  pwdata,
	output logic [ccns_pkg::PDATA_W-1:0]  prdata,
	output logic [CB-1:0]                 mul,
	output logic [CB:0]                   den,
	output logic [2*CB-1:0]               offx,
	output logic [2*CB-1:0]               offy,
	output logic [2*CB:0]                 limx,
	output logic [2*CB:0]                 limy,
	output logic [CB-1:0]                 szx,
	output logic [CB-1:0]                 szy
);

	localparam int PW = 2 * CB;
	localparam int LW = 2 * CB + 1;
	localparam logic [CB-1:0] ONE = CB'(1);

	function automatic logic [CB-1:0] nz(input logic [CB-1:0] v);
		return (v == '0) ? ONE : v;
	endfunction

	ccns_pkg::reg_idx_t idx;
	logic               wr;
	logic [CB-1:0]      wdat;
	logic [CB-1:0]      sw_q, sh_q, tw_q, th_q;
	logic [CB-1:0]      sw_d, sh_d, tw_d, th_d;
	logic [CB-1:0]      esw_q, esh_q, etw_q, eth_q;
	logic [PW-1:0]      pws_q, phs_q;
	logic               wdom;
	logic [PW-1:0]      off;
	logic [CB-1:0]      mul_q;
	logic [CB:0]        den_q;
	logic [PW-1:0]      offx_q, offy_q;
	logic [LW-1:0]      limx_q, limy_q;
	logic [CB-1:0]      szx_q, szy_q;

	assign idx  = ccns_pkg::reg_idx_t'(paddr[3:2]);
	assign wr   = psel && penable && pwrite;
	assign wdat = pwdata[CB-1:0];

	always_comb begin
		sw_d = sw_q;
		sh_d = sh_q;
		tw_d = tw_q;
		th_d = th_q;
		if (wr) begin
			case (idx)
				ccns_pkg::REG_SRC_W: sw_d = wdat;
				ccns_pkg::REG_SRC_H: sh_d = wdat;
				ccns_pkg::REG_TGT_W: tw_d = wdat;
				ccns_pkg::REG_TGT_H: th_d = wdat;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			ccns_pkg::REG_SRC_W: prdata = ccns_pkg::PDATA_W'(sw_q);
			ccns_pkg::REG_SRC_H: prdata = ccns_pkg::PDATA_W'(sh_q);
			ccns_pkg::REG_TGT_W: prdata = ccns_pkg::PDATA_W'(tw_q);
			ccns_pkg::REG_TGT_H: prdata = ccns_pkg::PDATA_W'(th_q);
			default:             prdata = '0;
		endcase
	end

	// The cross products are taken from the next register values so that they
	// are registered together with the size registers themselves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q  <= ONE;
			sh_q  <= ONE;
			tw_q  <= ONE;
			th_q  <= ONE;
			esw_q <= ONE;
			esh_q <= ONE;
			etw_q <= ONE;
			eth_q <= ONE;
			pws_q <= PW'(1);
			phs_q <= PW'(1);
		end else begin
			sw_q  <= sw_d;
			sh_q  <= sh_d;
			tw_q  <= tw_d;
			th_q  <= th_d;
			esw_q <= nz(sw_d);
			esh_q <= nz(sh_d);
			etw_q <= nz(tw_d);
			eth_q <= nz(th_d);
			pws_q <= PW'(nz(tw_d)) * PW'(nz(sh_d));
			phs_q <= PW'(nz(th_d)) * PW'(nz(sw_d));
		end
	end

	// Width dominates when tw/sw beats th/sh; a tie goes to the height.
	assign wdom = pws_q > phs_q;
	assign off  = wdom ? (pws_q - phs_q) : (phs_q - pws_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q  <= ONE;
			den_q  <= (CB+1)'(2);
			offx_q <= '0;
			offy_q <= '0;
			szx_q  <= '0;
			szy_q  <= '0;
			limx_q <= LW'(2);
			limy_q <= LW'(2);
		end else begin
			mul_q  <= wdom ? esw_q : esh_q;
			den_q  <= wdom ? {etw_q, 1'b0} : {eth_q, 1'b0};
			offx_q <= wdom ? '0 : off;
			offy_q <= wdom ? off : '0;
			szx_q  <= esw_q - ONE;
			szy_q  <= esh_q - ONE;
			limx_q <= LW'(esw_q) * LW'(den_q);
			limy_q <= LW'(esh_q) * LW'(den_q);
		end
	end

	assign mul  = mul_q;
	assign den  = den_q;
	assign offx = offx_q;
	assign offy = offy_q;
	assign limx = limx_q;
	assign limy = limy_q;
	assign szx  = szx_q;
	assign szy  = szy_q;

endmodule

// ===== design/ccns_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with edge clamping at the end.
module ccns_div #(
	parameter int CB = 11
) (
	input  logic              clk,
	input  logic [CB-1:0]     en,
	input  logic [2*CB+1:0]   num,
	input  logic              sat,
	input  logic [CB:0]       den,
	input  logic [CB-1:0]     szm1,
	output logic [CB-1:0]     res,
	output logic              sat_out
);

	localparam int NW = 2 * CB + 2;

	logic [NW-1:0] rem_s [CB-1];
	logic [CB-1:0] quo_s [CB];
	logic          sat_s [CB];

	genvar k;
	for (k = 0; k < CB; k++) begin : g_stage
		logic [NW-1:0] rem_in;
		logic [NW-1:0] trial;
		logic [CB-1:0] quo_in;
		logic          sat_in;
		logic          fit;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign quo_in = '0;
			assign sat_in = sat;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
			assign sat_in = sat_s[k-1];
		end

		assign trial = NW'(den) << (CB - 1 - k);
		assign fit   = rem_in >= trial;

		always_ff @(posedge clk) begin
			if (en[k]) begin
				quo_s[k] <= {quo_in[CB-2:0], fit};
				sat_s[k] <= sat_in;
			end
		end

		if (k < CB - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en[k]) begin
					rem_s[k] <= fit ? (rem_in - trial) : rem_in;
				end
			end
		end
	end

	assign res     = sat_s[CB-1] ? szm1 : quo_s[CB-1];
	assign sat_out = sat_s[CB-1];

endmodule

// ===== design/cover_crop_nearest_scaler_addr_top.sv =====
// Top level of the cover-crop nearest-neighbour scaler address generator.
//
// Channel   Direction  Handshake              Beat contents
// coord     in         coord_valid/ready      preview column and row (out_x, out_y)
// addr      out        addr_valid/ready       source column, source row, clamp flag
// apb       in         psel/penable/pready    one of four size registers, 4-byte spaced
//
// One beat is accepted per clock while coord_ready is high; a result passes the
// front stages and then the divider, which resolves one quotient bit per stage.
// Reset is asynchronous and active low; it empties the pipeline and sets all
// four size registers to one. Each stage moves forward whenever it or any stage
// after it has a free slot, so bubbles are squeezed out and a held result at the
// output does not stop new coordinates entering while room remains upstream.
// Size registers may be rewritten only while no beat is in flight.
module cover_crop_nearest_scaler_addr_top #(
	parameter int COORD_BITS = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          coord_valid,
	output logic                          coord_ready,
	input  ccns_pkg::coord_t              coord,
	output logic                          addr_valid,
	input  logic                          addr_ready,
	output ccns_pkg::addr_t               addr,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ccns_pkg::PADDR_W-1:0]  paddr,
	input  logic [ccns_pkg::PDATA_W-1:0]  pwdata,
	output logic [ccns_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	localparam int CB  = COORD_BITS;
	localparam int NW  = 2 * CB + 2;
	localparam int PW  = 2 * CB + 1;
	// Five front stages (capture, odd coordinate, product, offset add, clamp
	// compare) followed by one divider stage per quotient bit.
	localparam int NST = 5 + CB;

	logic [CB-1:0]  mul;
	logic [CB:0]    den;
	logic [2*CB-1:0] offx, offy;
	logic [PW-1:0]  limx, limy;
	logic [CB-1:0]  szx, szy;

	logic [NST:1]   vld_s;
	logic [NST:1]   en;

	logic [CB-1:0]  x_s1, y_s1;
	logic [CB:0]    oddx_s2, oddy_s2;
	logic [PW-1:0]  px_s3, py_s3;
	logic [NW-1:0]  numx_s4, numy_s4;
	logic [NW-1:0]  numx_s5, numy_s5;
	logic           satx_s5, saty_s5;

	logic [CB-1:0]  resx, resy;
	logic           hitx, hity;

	assign pready = 1'b1;

	ccns_cfg #(
		.CB (CB)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.mul     (mul),
		.den     (den),
		.offx    (offx),
		.offy    (offy),
		.limx    (limx),
		.limy    (limy),
		.szx     (szx),
		.szy     (szy)
	);

	// A stage may load when the output is being taken or when there is an
	// empty slot anywhere from this stage to the output.
	genvar g;
	for (g = 1; g <= NST; g++) begin : g_en
		assign en[g] = addr_ready || !(&vld_s[NST:g]);
	end

	assign coord_ready = en[1];
	assign addr_valid  = vld_s[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= coord_valid;
			end
			for (int i = 2; i <= NST; i++) begin
				if (en[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// Sampling at pixel centres turns each coordinate into the odd value 2c+1;
	// the dominant-axis size then scales both axes, and the cropped axis picks
	// up the centring offset before the floor division by twice the target.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			x_s1 <= CB'(coord.out_x);
			y_s1 <= CB'(coord.out_y);
		end
		if (en[2]) begin
			oddx_s2 <= {x_s1, 1'b1};
			oddy_s2 <= {y_s1, 1'b1};
		end
		if (en[3]) begin
			px_s3 <= PW'(oddx_s2) * PW'(mul);
			py_s3 <= PW'(oddy_s2) * PW'(mul);
		end
		if (en[4]) begin
			numx_s4 <= NW'(px_s3) + NW'(offx);
			numy_s4 <= NW'(py_s3) + NW'(offy);
		end
		// The quotient reaches the source size exactly when the numerator
		// reaches size times divisor, so the clamp is known before dividing.
		if (en[5]) begin
			numx_s5 <= numx_s4;
			numy_s5 <= numy_s4;
			satx_s5 <= numx_s4 >= NW'(limx);
			saty_s5 <= numy_s4 >= NW'(limy);
		end
	end

	ccns_div #(
		.CB (CB)
	) u_div_x (
		.clk     (clk),
		.en      (en[NST:6]),
		.num     (numx_s5),
		.sat     (satx_s5),
		.den     (den),
		.szm1    (szx),
		.res     (resx),
		.sat_out (hitx)
	);

	ccns_div #(
		.CB (CB)
	) u_div_y (
		.clk     (clk),
		.en      (en[NST:6]),
		.num     (numy_s5),
		.sat     (saty_s5),
		.den     (den),
		.szm1    (szy),
		.res     (resy),
		.sat_out (hity)
	);

	always_comb begin
		addr.src_x   = ccns_pkg::FIELD_W'(resx);
		addr.src_y   = ccns_pkg::FIELD_W'(resy);
		addr.clamped = hitx || hity;
	end

	// Every delivered address lies inside the source image.
	a_in_bounds : assert property (@(posedge clk) disable iff (!arst_n)
		addr_valid |-> (resx <= szx) && (resy <= szy))
		else $error("source address beyond the source edge");

	// A set clamp flag means at least one axis sits on the last source pixel.
	a_clamp_edge : assert property (@(posedge clk) disable iff (!arst_n)
		addr_valid && addr.clamped |-> (resx == szx) || (resy == szy))
		else $error("clamp flag without an edge address");

	// Any empty slot in the pipeline must let a new coordinate in.
	a_bubble_ready : assert property (@(posedge clk) disable iff (!arst_n)
		!(&vld_s) |-> coord_ready)
		else $error("input stalled while the pipeline has room");

	// An output held back keeps its beat in the last stage.
	a_hold_last : assert property (@(posedge clk) disable iff (!arst_n)
		addr_valid && !addr_ready |=> addr_valid && $stable(resx) && $stable(resy))
		else $error("held result lost or changed in the last stage");

endmodule

// ===== sim/ccns_addr_checker.sv =====
// Checker that tracks the size registers, predicts each source address and compares the results.
module ccns_addr_checker
	import ccns_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               coord_valid,
	input  logic               coord_ready,
	input  coord_t             coord,
	input  logic               addr_valid,
	input  logic               addr_ready,
	input  addr_t              addr,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               pready,
	output int                 mismatches,
	output int                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [FIELD_W-1:0] src_w;
	logic [FIELD_W-1:0] src_h;
	logic [FIELD_W-1:0] tgt_w;
	logic [FIELD_W-1:0] tgt_h;
	addr_t              due_addrs[$];
	int                 fail_count = 0;

	assign mismatches = fail_count;

	// Cover scale with centre crop, all in exact integer ratios; a size of zero counts as one.
	function automatic addr_t map_to_source(coord_t c);
		longint unsigned sw;
		longint unsigned sh;
		longint unsigned tw;
		longint unsigned th;
		longint unsigned x;
		longint unsigned y;
		longint unsigned sx;
		longint unsigned sy;
		addr_t           r;
		sw = (src_w == '0) ? 64'd1 : 64'(src_w);
		sh = (src_h == '0) ? 64'd1 : 64'(src_h);
		tw = (tgt_w == '0) ? 64'd1 : 64'(tgt_w);
		th = (tgt_h == '0) ? 64'd1 : 64'(tgt_h);
		x = 64'(c.out_x);
		y = 64'(c.out_y);
		if (tw * sh > th * sw) begin
			sx = ((2 * x + 1) * sw) / (2 * tw);
			sy = (sh * tw - th * sw + (2 * y + 1) * sw) / (2 * tw);
		end else begin
			sy = ((2 * y + 1) * sh) / (2 * th);
			sx = (sw * th - tw * sh + (2 * x + 1) * sh) / (2 * th);
		end
		r.clamped = 1'b0;
		if (sx >= sw) begin
			sx = sw - 1;
			r.clamped = 1'b1;
		end
		if (sy >= sh) begin
			sy = sh - 1;
			r.clamped = 1'b1;
		end
		r.src_x = sx[FIELD_W-1:0];
		r.src_y = sy[FIELD_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		addr_t want;
		if (!arst_n) begin
			src_w <= FIELD_W'(1);
			src_h <= FIELD_W'(1);
			tgt_w <= FIELD_W'(1);
			tgt_h <= FIELD_W'(1);
			due_addrs.delete();
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_SRC_W: src_w <= pwdata[FIELD_W-1:0];
					REG_SRC_H: src_h <= pwdata[FIELD_W-1:0];
					REG_TGT_W: tgt_w <= pwdata[FIELD_W-1:0];
					REG_TGT_H: tgt_h <= pwdata[FIELD_W-1:0];
					default: ;
				endcase
			end
			// A result is popped before this edge's coordinate is queued: no beat can
			// come back in the cycle it went in.
			if (addr_valid && addr_ready) begin
				if (due_addrs.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result: src_x=%0d src_y=%0d clamped=%0d",
							addr.src_x, addr.src_y, addr.clamped);
					fail_count++;
				end else begin
					want = due_addrs.pop_front();
					if (want.src_x !== addr.src_x || want.src_y !== addr.src_y ||
							want.clamped !== addr.clamped) begin
						if (fail_count < 10)
							$display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
								want.src_x, want.src_y, want.clamped,
								addr.src_x, addr.src_y, addr.clamped);
						fail_count++;
					end
				end
			end
			if (coord_valid && coord_ready)
				due_addrs.insert(due_addrs.size(), map_to_source(coord));
			outstanding <= due_addrs.size();
		end
	end

endmodule

// ===== sim/tb_cover_crop_nearest_scaler_addr_top.sv =====
// Testbench top: drives coordinates, size registers and result back-pressure, and reports the verdict.
module tb_cover_crop_nearest_scaler_addr_top;
	import ccns_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Latency of the block under test, used to size the final wait.
	localparam int LATENCY     = 15;
	// Long enough, with the pipeline depth above, for the block to fill and stall its input.
	localparam int HOLD_CYCLES = 80;
	localparam int MAX_COORD   = (1 << FIELD_W) - 1;

	logic               clk;
	logic               arst_n;
	logic               coord_valid;
	logic               coord_ready;
	coord_t             coord;
	logic               addr_valid;
	logic               addr_ready;
	addr_t              addr;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 mismatches;
	int                 outstanding;

	// Idle rates in percent per cycle; the stimulus process moves them between phases.
	int tx_idle_pct   = 8;
	int rx_idle_pct   = 46;
	// The stimulus bumps the request count; the receiver catches up once it has held off.
	int hold_req_seq  = 0;
	int hold_done_seq = 0;
	// Effective preview size currently programmed, used to aim coordinates at the image.
	int cur_tw        = 1;
	int cur_th        = 1;

	cover_crop_nearest_scaler_addr_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.coord_valid(coord_valid),
		.coord_ready(coord_ready),
		.coord      (coord),
		.addr_valid (addr_valid),
		.addr_ready (addr_ready),
		.addr       (addr),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	ccns_addr_checker addr_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.coord_valid(coord_valid),
		.coord_ready(coord_ready),
		.coord      (coord),
		.addr_valid (addr_valid),
		.addr_ready (addr_ready),
		.addr       (addr),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial clk = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The register keeps only the low bits, and zero behaves as one.
	function automatic int effective(logic [PDATA_W-1:0] v);
		return (v[FIELD_W-1:0] == 0) ? 1 : int'(v[FIELD_W-1:0]);
	endfunction

	// Mostly the full range of real sizes with a bias to small images, plus the edges,
	// zero and values carrying junk above the register width.
	function automatic logic [PDATA_W-1:0] random_size();
		case ($urandom_range(9))
			0: return 1;
			1: return MAX_COORD;
			2, 3, 4: return $urandom_range(1, 64);
			5, 6: return $urandom_range(1, MAX_COORD);
			7: return $urandom_range(100, 800);
			8: return 0;
			default: return {21'($urandom()), 11'($urandom_range(1, MAX_COORD))};
		endcase
	endfunction

	// Most coordinates land inside the preview, some just past its edge, a few anywhere.
	function automatic int next_axis(int size);
		int pick;
		int v;
		pick = $urandom_range(9);
		if (pick < 7)
			return $urandom_range(size - 1);
		if (pick < 9) begin
			v = size - 1 + $urandom_range(2);
			return (v > MAX_COORD) ? MAX_COORD : v;
		end
		return $urandom_range(MAX_COORD);
	endfunction

	// Offers one coordinate beat, after a random idle stretch, and returns on the edge
	// that accepts it with valid still high, so a following beat can go straight out.
	task automatic send_xy(input int x, input int y);
		coord_t beat;
		int     gap;
		beat.out_x = FIELD_W'(x);
		beat.out_y = FIELD_W'(y);
		gap = 0;
		while (gap < 20 && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap != 0) begin
			coord_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		coord_valid <= 1'b1;
		coord <= beat;
		do @(posedge clk); while (!coord_ready);
	endtask

	// The checker's count only includes the latest accepted beat one edge later, hence
	// the wait comes before the first look.
	task automatic wait_drained();
		do @(posedge clk); while (outstanding != 0);
	endtask

	// One APB write: setup cycle, access cycle, then a spare cycle so the select can
	// drop before the next transfer starts.
	task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Sizes change only with nothing in flight.
	task automatic set_sizes(input logic [PDATA_W-1:0] sw, input logic [PDATA_W-1:0] sh,
			input logic [PDATA_W-1:0] tw, input logic [PDATA_W-1:0] th);
		coord_valid <= 1'b0;
		wait_drained();
		write_reg(REG_SRC_W, sw);
		write_reg(REG_SRC_H, sh);
		write_reg(REG_TGT_W, tw);
		write_reg(REG_TGT_H, th);
		cur_tw = effective(tw);
		cur_th = effective(th);
	endtask

	// The first preview pixel, the last one, and the far corner of the coordinate space.
	task automatic probe_corners();
		send_xy(0, 0);
		send_xy(cur_tw - 1, cur_th - 1);
		send_xy(MAX_COORD, MAX_COORD);
	endtask

	// The receiver: random back-pressure, or a long hold-off when the stimulus asks for
	// one. The hold-off is counted here so the sender keeps offering beats meanwhile.
	initial begin
		addr_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_done_seq != hold_req_seq) begin
				addr_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done_seq = hold_req_seq;
			end else begin
				addr_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		int phase;
		int n;
		int saved_tx;
		arst_n <= 1'b0;
		coord_valid <= 1'b0;
		coord <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sizes are all one, so every coordinate but the origin must clamp.
		send_xy(0, 0);
		send_xy(MAX_COORD, MAX_COORD);
		send_xy(0, MAX_COORD);
		send_xy(MAX_COORD, 0);

		// Directed settings: the largest image with a tie, both extreme aspect ratios,
		// a wide and a tall preview of an ordinary image, an exact tie, and lastly zeros
		// and junk above the register width.
		set_sizes(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD);
		probe_corners();
		set_sizes(1, MAX_COORD, MAX_COORD, 1);
		probe_corners();
		set_sizes(MAX_COORD, 1, 1, MAX_COORD);
		probe_corners();
		set_sizes(640, 480, 800, 480);
		probe_corners();
		set_sizes(640, 480, 320, 480);
		probe_corners();
		set_sizes(640, 480, 320, 240);
		probe_corners();
		set_sizes(0, 32'h8000_0000, 32'hFFFF_F000 | 100, 32'hABCD_0000 | 300);
		probe_corners();

		// Random part: thirteen settings of a hundred beats each. The first stretch has a
		// slow receiver, the second a slow sender, the last no idling on either side.
		for (phase = 0; phase < 13; phase++) begin
			if (phase == 5) begin
				tx_idle_pct = 46;
				rx_idle_pct = 8;
			end else if (phase == 9) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			set_sizes(random_size(), random_size(), random_size(), random_size());
			n = 0;
			if (phase == 3) begin
				// Back-to-back beats into a stalled output fill the pipeline until the
				// block refuses further input.
				hold_req_seq++;
				saved_tx = tx_idle_pct;
				tx_idle_pct = 0;
				for (; n < 40; n++)
					send_xy(next_axis(cur_tw), next_axis(cur_th));
				tx_idle_pct = saved_tx;
			end
			for (; n < 100; n++)
				send_xy(next_axis(cur_tw), next_axis(cur_th));
		end

		// Wait for the last results, then a little longer to catch any stray beat.
		coord_valid <= 1'b0;
		wait_drained();
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Timeout: far beyond the slowest correct run.
	initial begin
		#200_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
